// File: hw/rtl/hsa_pkg.sv
package hsa_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 64;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 11;
	localparam int ENV_W    = 64;
	localparam int HOUT_W   = 10;
	localparam int LIVE_W   = 11;
	localparam int STAT_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_GET   = 2'd1,
		OP_FREE  = 2'd2,
		OP_COUNT = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FREED = 2'd3
	} status_t;

endpackage

// File: hw/rtl/hsa_req_if.sv
interface hsa_req_if;
	import hsa_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 op;
	logic [HANDLE_W-1:0] handle;
	logic [ENV_W-1:0]    env_value;

	modport source (output valid, output op, output handle, output env_value, input ready);
	modport sink (input valid, input op, input handle, input env_value, output ready);

endinterface

// File: hw/rtl/hsa_rsp_if.sv
interface hsa_rsp_if;
	import hsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [HOUT_W-1:0] handle_out;
	logic [ENV_W-1:0]  value_out;
	logic [LIVE_W-1:0] live_count;
	status_t           status;

	modport source (
		output valid, output handle_out, output value_out, output live_count, output status,
		input ready
	);
	modport sink (
		input valid, input handle_out, input value_out, input live_count, input status,
		output ready
	);

endinterface

// File: hw/rtl/hsa_ram.sv
module hsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/handle_slot_allocator_unit.sv
// Handle table with a recycling allocator. Each request (alloc, get, free, live count) is
// accepted in S_IDLE, which reads the slot memory and the free-index stack; in S_EXEC the
// result is formed, the memories are written back as the op needs and the counters move.
// No new request is taken during S_EXEC. The result sits in an output register, so the
// next request is taken while a result still waits; a request stalls in S_EXEC only while
// that register is full and not being read. The memories start undefined, need no clearing
// pass: only slots below the fresh-index counter and stack entries below the depth are read.
module handle_slot_allocator_unit #(
	parameter int SLOTS      = hsa_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = hsa_pkg::VALUE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hsa_req_if.sink    req,
	hsa_rsp_if.source  rsp
);
	import hsa_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      free_depth_q;
	logic [CNT_W-1:0]      fresh_q;
	logic [CNT_W-1:0]      live_q;
	logic                  rsp_valid_q;
	logic [HOUT_W-1:0]     rsp_handle_q;
	logic [ENV_W-1:0]      rsp_value_q;
	logic [LIVE_W-1:0]     rsp_live_q;
	status_t               rsp_status_q;

	op_t                   op_s1;
	logic [IDX_W-1:0]      h_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic                  in_range_s1;

	logic                  accept;
	logic                  fire;
	logic [CMP_W-1:0]      h_ext;
	logic                  in_range;
	logic [CNT_W-1:0]      depth_m1;
	logic                  from_stack;
	logic                  have_fresh;
	logic [IDX_W-1:0]      grant;
	logic                  slot_empty;
	logic                  alloc_ok;
	logic                  free_ok;
	logic [HOUT_W-1:0]     res_handle;
	logic [ENV_W-1:0]      res_value;
	status_t               res_status;
	logic [CNT_W-1:0]      live_next;

	logic                  slot_wr_en;
	logic [IDX_W-1:0]      slot_wr_addr;
	logic [VALUE_BITS-1:0] slot_wr_data;
	logic [VALUE_BITS-1:0] slot_rd_data;
	logic                  stk_wr_en;
	logic [IDX_W-1:0]      stk_rd_data;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign h_ext     = CMP_W'(req.handle);
	assign in_range  = (h_ext < CMP_W'(fresh_q)) && (h_ext < CMP_W'(SLOTS));
	assign depth_m1  = free_depth_q - CNT_W'(1);

	hsa_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.rd_en   (accept),
		.rd_addr (h_ext[IDX_W-1:0]),
		.rd_data (slot_rd_data)
	);

	hsa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SLOTS)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (free_depth_q[IDX_W-1:0]),
		.wr_data (h_s1),
		.rd_en   (accept),
		.rd_addr (depth_m1[IDX_W-1:0]),
		.rd_data (stk_rd_data)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= req.op;
			h_s1        <= h_ext[IDX_W-1:0];
			val_s1      <= VALUE_BITS'(req.env_value);
			in_range_s1 <= in_range;
		end
	end

	always_comb begin
		fire       = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
		from_stack = (free_depth_q != '0);
		have_fresh = (fresh_q < CNT_W'(SLOTS));
		grant      = from_stack ? stk_rd_data : fresh_q[IDX_W-1:0];
		slot_empty = (slot_rd_data == '0);
		alloc_ok   = 1'b0;
		free_ok    = 1'b0;
		res_handle = '0;
		res_value  = '0;
		res_status = STAT_OK;
		unique case (op_s1)
			OP_ALLOC: begin
				if (from_stack || have_fresh) begin
					alloc_ok   = 1'b1;
					res_handle = HOUT_W'(grant);
				end else begin
					res_status = STAT_FULL;
				end
			end
			OP_GET: begin
				if (in_range_s1) begin
					res_value = ENV_W'(slot_rd_data);
				end else begin
					res_status = STAT_RANGE;
				end
			end
			OP_FREE: begin
				if (!in_range_s1) begin
					res_status = STAT_RANGE;
				end else if (slot_empty) begin
					res_status = STAT_FREED;
				end else begin
					free_ok = 1'b1;
				end
			end
			OP_COUNT: begin
			end
		endcase

		live_next = live_q;
		if (alloc_ok && (live_q < CNT_W'(SLOTS))) begin
			live_next = live_q + CNT_W'(1);
		end else if (free_ok && (live_q != '0)) begin
			live_next = live_q - CNT_W'(1);
		end

		slot_wr_en   = fire && (alloc_ok || free_ok);
		slot_wr_addr = alloc_ok ? grant : h_s1;
		slot_wr_data = alloc_ok ? val_s1 : '0;
		stk_wr_en    = fire && free_ok && (free_depth_q < CNT_W'(SLOTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_depth_q <= '0;
			fresh_q      <= '0;
			live_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_handle_q <= '0;
			rsp_value_q  <= '0;
			rsp_live_q   <= '0;
			rsp_status_q <= STAT_OK;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q      <= S_IDLE;
						rsp_handle_q <= res_handle;
						rsp_value_q  <= res_value;
						rsp_live_q   <= LIVE_W'(live_next);
						rsp_status_q <= res_status;
						live_q       <= live_next;
						if (alloc_ok && from_stack) begin
							free_depth_q <= depth_m1;
						end else if (stk_wr_en) begin
							free_depth_q <= free_depth_q + CNT_W'(1);
						end
						if (alloc_ok && !from_stack) begin
							fresh_q <= fresh_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.handle_out = rsp_handle_q;
	assign rsp.value_out  = rsp_value_q;
	assign rsp.live_count = rsp_live_q;
	assign rsp.status     = rsp_status_q;

	// every handed-out index is either live or on the stack
	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(live_q) + (CNT_W + 1)'(free_depth_q) == (CNT_W + 1)'(fresh_q))
		else $error("live and free counts do not add up to the fresh index");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_depth_q <= fresh_q)
		else $error("free stack deeper than the handed-out range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q && (state_q == S_IDLE))
		else $error("completed request did not load the result register");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !accept)
		else $error("transfer accepted while a request is in progress");

	a_full_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == STAT_FULL)) |-> (rsp_handle_q == '0))
		else $error("failed alloc reports a handle");

endmodule
